[hdl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/lge_pkg.sv]
// Shared constants, types and helpers for the Life generation engine.
`default_nettype none

package lge_pkg;

    // Grid limits
    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    // Width of the size registers
    localparam int DIM_W       = 7;

    typedef logic [MAX_COLUMNS-1:0] row_t;

    // Command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_GEN,
        ST_FINISH
    } st_t;

    // One computed row and whether it differs from the current one
    typedef struct packed {
        row_t next_row;
        logic changed;
    } row_res_t;

    // Clamp a size register to 1..hi
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/lge_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lge_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/lge_lane.sv]
// One cell lane: B3/S23 rule from the eight neighbor bits.
`default_nettype none

module lge_lane (
    input  wire logic [7:0] nbr,
    input  wire logic       self_alive,
    input  wire logic       in_use,
    output logic            alive_next
);

    logic [3:0] sum;

    // Neighbor count
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < 8; i++)
        begin
            sum = sum + {3'b000, nbr[i]};
        end
    end

    // Birth on three, survival on two or three; columns past the width stay dead
    assign alive_next = in_use & ((sum == 4'd3) | ((sum == 4'd2) & self_alive));

endmodule

`default_nettype wire

[hdl/lge_row_unit.sv]
// Row of cell lanes with horizontal wrap, plus merge into next row and change flag.
`default_nettype none

module lge_row_unit (
    input  wire lge_pkg::row_t                  up,
    input  wire lge_pkg::row_t                  mid,
    input  wire lge_pkg::row_t                  dn,
    input  wire logic [lge_pkg::DIM_W-1:0]      width,
    input  wire lge_pkg::row_t                  mask,
    output lge_pkg::row_res_t                   res
);

    import lge_pkg::*;

    logic [COL_W-1:0] last_col;
    row_t             lane_out;

    assign last_col = COL_W'(width - DIM_W'(1));

    // One lane per column
    for (genvar x = 0; x < MAX_COLUMNS; x++)
    begin : g_lane
        logic is_last;
        logic wu, wm, wd;
        logic eu, em, ed;

        assign is_last = (last_col == COL_W'(x));

        // West neighbor: column x-1, first column wraps to the last one in use
        if (x == 0)
        begin : g_west_edge
            assign wu = up[last_col];
            assign wm = mid[last_col];
            assign wd = dn[last_col];
        end
        else
        begin : g_west
            assign wu = up[x-1];
            assign wm = mid[x-1];
            assign wd = dn[x-1];
        end

        // East neighbor: column x+1, last column in use wraps to column 0
        if (x == MAX_COLUMNS - 1)
        begin : g_east_edge
            assign eu = is_last & up[0];
            assign em = is_last & mid[0];
            assign ed = is_last & dn[0];
        end
        else
        begin : g_east
            assign eu = is_last ? up[0]  : up[x+1];
            assign em = is_last ? mid[0] : mid[x+1];
            assign ed = is_last ? dn[0]  : dn[x+1];
        end

        lge_lane u_lane (
            .nbr        ({wu, up[x], eu, wm, em, wd, dn[x], ed}),
            .self_alive (mid[x]),
            .in_use     (mask[x]),
            .alive_next (lane_out[x])
        );
    end

    // Merge lane results
    assign res.next_row = lane_out;
    assign res.changed  = |(lane_out ^ mid);

endmodule

`default_nettype wire

[hdl/life_generation_engine_top.sv]
// Top level of the Life generation engine: control, grid memories, row window.
//
// Usage:
//   Input channel (in_valid/in_stall) transfers one command: write a row, run
//   generations, or read a row. Every command gives exactly one result on the
//   output channel (out_valid/out_stall). Commands are handled one at a time;
//   in_stall stays high from a transfer until its result is in the output
//   register. grid_width and grid_height are written through cfg_we/cfg_index/
//   cfg_data by the user only while no command is in flight; the block itself
//   does not enforce this.
// Sweep:
//   One generation sweeps the rows in use through a single read address, one
//   row per cycle, with all 64 cell lanes working on that row in parallel.
// Reset:
//   All cells read as dead, width and height return to 64. No sweep is needed:
//   a valid bit per row covers the cleared grid.
// Stall:
//   out_stall holds the result in the output register; one more command may be
//   taken, and its result waits inside with in_stall high until that register frees.
`default_nettype none

`include "assert_macros.svh"

module life_generation_engine_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Configuration
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [lge_pkg::DIM_W-1:0]      cfg_data,
    // Input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     cmd,
    input  wire logic [5:0]                     row_index,
    input  wire lge_pkg::row_t                  row_cells,
    input  wire logic [15:0]                    generations,
    // Output channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output lge_pkg::row_t                       row_cells_out,
    output logic [15:0]                         generations_done,
    output logic                                stable
);

    import lge_pkg::*;

    // Configuration and state
    logic [DIM_W-1:0]    width_reg, height_reg;
    logic [DIM_W-1:0]    w_use, h_use, h_last_full;
    logic [ROW_W-1:0]    h_last;
    row_t                mask;
    st_t                 state_reg, state_next;

    // Per-row bank select and valid bits
    logic [MAX_ROWS-1:0] row_sel_reg, row_vld_reg;

    // Command registers
    logic [15:0]         gens_reg, done_reg, done_inc;

    // Sweep pipeline
    logic [DIM_W-1:0]    gen_k_reg;
    logic [DIM_W-1:0]    rd_k_reg;
    logic                rd_pend_reg;
    logic                rd_sel_reg, rd_vld_reg;
    row_t                win_up_reg, win_mid_reg, win_dn_reg;
    logic                cmp_pend_reg;
    logic [ROW_W-1:0]    cmp_row_reg;
    logic                changed_reg, changed_all;
    logic                gen_last;

    // Result and output registers
    row_t                res_cells_reg;
    logic [15:0]         res_done_reg;
    logic                res_stable_reg;
    logic                out_valid_reg;
    row_t                out_cells_reg;
    logic [15:0]         out_done_reg;
    logic                out_stable_reg;

    // Memory ports
    logic                wr_en, wr_bank, wr_cmd;
    logic [ROW_W-1:0]    wr_addr, raddr;
    row_t                wr_data;
    row_t                dout_a, dout_b, rd_row;
    logic                issue;
    logic [DIM_W-1:0]    issue_addr;

    logic                accept, out_free;
    row_res_t            row_res;

    // Sizes in use and column mask
    assign w_use       = clamp_dim(width_reg, DIM_W'(MAX_COLUMNS));
    assign h_use       = clamp_dim(height_reg, DIM_W'(MAX_ROWS));
    assign h_last_full = h_use - DIM_W'(1);
    assign h_last      = h_last_full[ROW_W-1:0];

    always_comb
    begin
        for (int x = 0; x < MAX_COLUMNS; x++)
        begin
            mask[x] = (DIM_W'(x) < w_use);
        end
    end

    assign accept   = in_valid & ~in_stall;
    assign out_free = ~out_valid_reg | ~out_stall;
    assign done_inc = done_reg + 16'd1;

    // Sweep read order: last row, rows 0..h-1, then row 0 again
    always_comb
    begin
        if (gen_k_reg == '0)
        begin
            issue_addr = h_last_full;
        end
        else if ((gen_k_reg - DIM_W'(1)) == h_use)
        begin
            issue_addr = '0;
        end
        else
        begin
            issue_addr = gen_k_reg - DIM_W'(1);
        end
    end

    // Final row of a generation is being computed
    assign changed_all = changed_reg | row_res.changed;
    assign gen_last    = (state_reg == ST_GEN) & cmp_pend_reg & (cmp_row_reg == h_last);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_RUN:  state_next = (generations == '0) ? ST_FINISH : ST_GEN;
                        CMD_READ: state_next = ST_READ;
                        default:  state_next = ST_FINISH;
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_FINISH;
            end
            ST_GEN:
            begin
                if (gen_last && (!changed_all || done_inc == gens_reg))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs: handshake, memory read and write control
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        issue    = 1'b0;
        raddr    = ROW_W'(row_index);
        wr_cmd   = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = ROW_W'(row_index);
        wr_data  = row_cells;
        wr_bank  = row_sel_reg[ROW_W'(row_index)];
        unique case (state_reg)
            ST_IDLE:
            begin
                wr_cmd = accept & (cmd == CMD_WRITE);
                wr_en  = wr_cmd;
            end
            ST_GEN:
            begin
                issue   = ({1'b0, gen_k_reg} <= ({1'b0, h_use} + (DIM_W + 1)'(1)));
                raddr   = issue_addr[ROW_W-1:0];
                wr_en   = cmp_pend_reg;
                wr_addr = cmp_row_reg;
                wr_data = row_res.next_row;
                wr_bank = ~row_sel_reg[cmp_row_reg];
            end
            default:
            begin
            end
        endcase
    end

    // Two banks; each row lives in the bank its select bit names
    lge_ram #(
        .WIDTH (MAX_COLUMNS),
        .DEPTH (MAX_ROWS)
    ) u_ram_a (
        .clk   (clk),
        .we    (wr_en & ~wr_bank),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (raddr),
        .rdata (dout_a)
    );

    lge_ram #(
        .WIDTH (MAX_COLUMNS),
        .DEPTH (MAX_ROWS)
    ) u_ram_b (
        .clk   (clk),
        .we    (wr_en & wr_bank),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (raddr),
        .rdata (dout_b)
    );

    // Row read back; rows never written read as dead
    assign rd_row = rd_vld_reg ? (rd_sel_reg ? dout_b : dout_a) : '0;

    // Lanes and merge for the row in the window
    lge_row_unit u_row_unit (
        .up    (win_up_reg),
        .mid   (win_mid_reg),
        .dn    (win_dn_reg),
        .width (w_use),
        .mask  (mask),
        .res   (row_res)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= DIM_W'(MAX_COLUMNS);
            height_reg    <= DIM_W'(MAX_ROWS);
            row_sel_reg   <= '0;
            row_vld_reg   <= '0;
            gen_k_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            cmp_pend_reg  <= 1'b0;
            changed_reg   <= 1'b0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    default:    width_reg  <= width_reg;
                endcase
            end

            // Row write marks the row valid
            if (wr_cmd)
            begin
                row_vld_reg[ROW_W'(row_index)] <= 1'b1;
            end

            // Commit a changing generation: swap banks of the rows in use
            if (gen_last && changed_all)
            begin
                for (int y = 0; y < MAX_ROWS; y++)
                begin
                    if (DIM_W'(y) < h_use)
                    begin
                        row_sel_reg[y] <= ~row_sel_reg[y];
                        row_vld_reg[y] <= 1'b1;
                    end
                end
            end

            // Sweep counter
            if (accept || gen_last)
            begin
                gen_k_reg <= '0;
            end
            else if (issue)
            begin
                gen_k_reg <= gen_k_reg + DIM_W'(1);
            end

            rd_pend_reg  <= issue;
            cmp_pend_reg <= rd_pend_reg & (rd_k_reg >= DIM_W'(2)) & (state_reg == ST_GEN);

            // Change flag over one generation
            if (accept || gen_last)
            begin
                changed_reg <= 1'b0;
            end
            else if (cmp_pend_reg)
            begin
                changed_reg <= changed_all;
            end

            // Generations applied
            if (accept)
            begin
                done_reg <= '0;
            end
            else if (gen_last && changed_all)
            begin
                done_reg <= done_inc;
            end

            if (out_free)
            begin
                out_valid_reg <= (state_reg == ST_FINISH);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_sel_reg  <= row_sel_reg[raddr];
        rd_vld_reg  <= row_vld_reg[raddr];
        rd_k_reg    <= gen_k_reg;
        cmp_row_reg <= ROW_W'(rd_k_reg - DIM_W'(2));

        // Three-row window shifts one row per read
        if (rd_pend_reg)
        begin
            win_up_reg  <= win_mid_reg;
            win_mid_reg <= win_dn_reg;
            win_dn_reg  <= rd_row & mask;
        end

        if (accept)
        begin
            gens_reg       <= generations;
            res_cells_reg  <= '0;
            res_done_reg   <= '0;
            res_stable_reg <= 1'b0;
        end
        else if (state_reg == ST_READ)
        begin
            res_cells_reg <= rd_row & mask;
        end
        else if (gen_last)
        begin
            res_done_reg   <= changed_all ? done_inc : done_reg;
            res_stable_reg <= ~changed_all;
        end

        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_cells_reg  <= res_cells_reg;
            out_done_reg   <= res_done_reg;
            out_stable_reg <= res_stable_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign row_cells_out    = out_cells_reg;
    assign generations_done = out_done_reg;
    assign stable           = out_stable_reg;

    // Row computations only happen during a run
    `ASSERT_IMPLIES(a_cmp_only_in_gen, clk, rst_n, cmp_pend_reg, state_reg == ST_GEN, "row compute outside a run")
    // A transfer always leaves idle
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, state_reg != ST_IDLE, "command taken but engine idle")
    // Sweep never runs past the wrapped last read
    `ASSERT_IMPLIES(a_sweep_bound, clk, rst_n, state_reg == ST_GEN, gen_k_reg <= h_use + DIM_W'(2), "sweep counter overran")

endmodule

`default_nettype wire

[tb/sv/tb_life_generation_engine_top.sv]
// Self-checking testbench for the Life generation engine: directed table, then random grids.
`timescale 1ns / 1ps

module tb_life_generation_engine_top;
    import lge_pkg::*;

    // Unknown opcode, answered with an all-zero result
    localparam logic [1:0] CMD_UNKNOWN     = 2'd3;
    localparam int         DIRECTED_COUNT  = 25;
    localparam int         PHASES          = 10;
    localparam int         ITEMS_PER_PHASE = 125;
    // Rough cycle budget for one run command
    localparam int         RUN_BUDGET      = 1500;
    localparam int         TIMEOUT_NS      = 50_000_000;
    localparam int         PRINT_CAP       = 200;

    typedef struct packed {
        row_t        cells;
        logic [15:0] gens_done;
        logic        stable;
    } life_result_t;

    typedef struct packed {
        logic [1:0]   op;
        logic [5:0]   row;
        row_t         cells;
        logic [15:0]  gens;
        logic         literal;
        life_result_t want;
    } stim_row_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic              cfg_index = REG_WIDTH;
    logic [DIM_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        cmd = CMD_WRITE;
    logic [5:0]        row_index = '0;
    row_t              row_cells = '0;
    logic [15:0]       generations = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    row_t              row_cells_out;
    logic [15:0]       generations_done;
    logic              stable;

    // Predicted grid and size registers
    row_t              grid_rows [MAX_ROWS];
    logic [DIM_W-1:0]  width_reg = 7'd64;
    logic [DIM_W-1:0]  height_reg = 7'd64;

    life_result_t      pending_results [$];
    life_result_t      head_result;

    int mismatch_count = 0;
    int results_checked = 0;
    int items_sent = 0;
    int writes_sent = 0;
    int reads_sent = 0;
    int runs_sent = 0;
    int stable_runs = 0;
    int gens_applied = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_span = 0;

    life_generation_engine_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .row_index        (row_index),
        .row_cells        (row_cells),
        .generations      (generations),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .row_cells_out    (row_cells_out),
        .generations_done (generations_done),
        .stable           (stable)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------
    // Life predictor
    // ---------------------------------------------------------------
    function automatic int clamp_size(input logic [DIM_W-1:0] v, input int hi);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > hi)
        begin
            return hi;
        end
        return int'(v);
    endfunction

    function automatic row_t live_mask(input int w);
        return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    // bit x takes column x-1, wrapping at the width
    function automatic row_t west_in(input row_t r, input int w, input row_t m);
        return ((r << 1) | (r >> (w - 1))) & m;
    endfunction

    // bit x takes column x+1, wrapping at the width
    function automatic row_t east_in(input row_t r, input int w, input row_t m);
        return ((r >> 1) | ((r & 64'd1) << (w - 1))) & m;
    endfunction

    // Per-lane 3-bit neighbor counter; eight neighbors wrap to zero
    function automatic void tally(input row_t a, inout row_t c0, inout row_t c1,
                                  inout row_t c2);
        row_t k0;
        row_t k1;
        k0 = c0 & a;
        c0 = c0 ^ a;
        k1 = c1 & k0;
        c1 = c1 ^ k0;
        c2 = c2 ^ k1;
    endfunction

    // One B3/S23 generation; grid only replaced when something changed
    function automatic bit step_generation(input int w, input int h, input row_t m);
        row_t fresh [MAX_ROWS];
        row_t up;
        row_t mid;
        row_t dn;
        row_t c0;
        row_t c1;
        row_t c2;
        bit   same;
        int   y;
        same = 1'b1;
        for (y = 0; y < h; y++)
        begin
            up  = grid_rows[(y + h - 1) % h] & m;
            mid = grid_rows[y] & m;
            dn  = grid_rows[(y + 1) % h] & m;
            c0 = '0;
            c1 = '0;
            c2 = '0;
            tally(west_in(up, w, m), c0, c1, c2);
            tally(up, c0, c1, c2);
            tally(east_in(up, w, m), c0, c1, c2);
            tally(west_in(mid, w, m), c0, c1, c2);
            tally(east_in(mid, w, m), c0, c1, c2);
            tally(west_in(dn, w, m), c0, c1, c2);
            tally(dn, c0, c1, c2);
            tally(east_in(dn, w, m), c0, c1, c2);
            fresh[y] = c1 & ~c2 & (c0 | mid) & m;
            if (fresh[y] != mid)
            begin
                same = 1'b0;
            end
        end
        if (!same)
        begin
            for (y = 0; y < h; y++)
            begin
                grid_rows[y] = fresh[y];
            end
        end
        return same;
    endfunction

    function automatic void run_generations(input int limit, output int done,
                                            output bit settled);
        int   w;
        int   h;
        row_t m;
        w = clamp_size(width_reg, MAX_COLUMNS);
        h = clamp_size(height_reg, MAX_ROWS);
        m = live_mask(w);
        done = 0;
        settled = 1'b0;
        while (done < limit && !settled)
        begin
            if (step_generation(w, h, m))
            begin
                settled = 1'b1;
            end
            else
            begin
                done++;
            end
        end
    endfunction

    // Trial run on a scratch copy: does the grid settle within the limit?
    function automatic bit settles_within(input int limit);
        row_t saved [MAX_ROWS];
        int   done;
        bit   settled;
        int   y;
        for (y = 0; y < MAX_ROWS; y++)
        begin
            saved[y] = grid_rows[y];
        end
        run_generations(limit, done, settled);
        for (y = 0; y < MAX_ROWS; y++)
        begin
            grid_rows[y] = saved[y];
        end
        return settled;
    endfunction

    function automatic life_result_t predict_command(input logic [1:0] op,
                                                     input logic [5:0] row,
                                                     input row_t cells,
                                                     input logic [15:0] gens);
        life_result_t r;
        int           done;
        bit           settled;
        r = '0;
        case (op)
            CMD_WRITE:
            begin
                grid_rows[row] = cells;
            end
            CMD_RUN:
            begin
                run_generations(int'(gens), done, settled);
                r.gens_done = done[15:0];
                r.stable = settled;
            end
            CMD_READ:
            begin
                r.cells = grid_rows[row] & live_mask(clamp_size(width_reg, MAX_COLUMNS));
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Directed table; literal rows carry their own expected result
    // ---------------------------------------------------------------
    function automatic stim_row_t directed_row(input int i);
        stim_row_t s;
        s = '0;
        case (i)
            // fresh grid reads dead
            0:  s = '{CMD_READ,    6'd0,  64'd0, 16'd0,      1'b1, '{64'd0, 16'd0, 1'b0}};
            1:  s = '{CMD_UNKNOWN, 6'd63, '1,    16'hFFFF,   1'b1, '{64'd0, 16'd0, 1'b0}};
            2:  s = '{CMD_RUN,     6'd0,  64'd0, 16'd0,      1'b1, '{64'd0, 16'd0, 1'b0}};
            // empty grid settles on the first generation
            3:  s = '{CMD_RUN,     6'd63, '1,    16'hFFFF,   1'b1, '{64'd0, 16'd0, 1'b1}};
            4:  s = '{CMD_WRITE,   6'd0,  '1,    16'd0,      1'b1, '{64'd0, 16'd0, 1'b0}};
            5:  s = '{CMD_WRITE,   6'd63, '1,    16'd0,      1'b1, '{64'd0, 16'd0, 1'b0}};
            6:  s = '{CMD_READ,    6'd0,  64'd0, 16'd0,      1'b1, '{'1,     16'd0, 1'b0}};
            // two full rows across the vertical wrap
            7:  s = '{CMD_RUN,     6'd0,  64'd0, 16'd1,      1'b0, '0};
            8:  s = '{CMD_READ,    6'd1,  64'd0, 16'd0,      1'b0, '0};
            9:  s = '{CMD_WRITE,   6'd1,  64'd0, 16'd0,      1'b1, '{64'd0, 16'd0, 1'b0}};
            10: s = '{CMD_WRITE,   6'd62, 64'd0, 16'd0,      1'b1, '{64'd0, 16'd0, 1'b0}};
            // block wrapped around the corner
            11: s = '{CMD_WRITE,   6'd63, 64'h8000_0000_0000_0001, 16'd0, 1'b1, '0};
            12: s = '{CMD_WRITE,   6'd0,  64'h8000_0000_0000_0001, 16'd0, 1'b1, '0};
            13: s = '{CMD_RUN,     6'd5,  64'd0, 16'hFFFF,   1'b0, '0};
            // blinker
            14: s = '{CMD_WRITE,   6'd31, 64'h0000_0001_C000_0000, 16'd0, 1'b1, '0};
            15: s = '{CMD_RUN,     6'd0,  64'd0, 16'd3,      1'b0, '0};
            16: s = '{CMD_READ,    6'd30, 64'd0, 16'd0,      1'b0, '0};
            17: s = '{CMD_READ,    6'd31, 64'd0, 16'd0,      1'b0, '0};
            // glider
            18: s = '{CMD_WRITE,   6'd40, 64'h2, 16'd0,      1'b1, '0};
            19: s = '{CMD_WRITE,   6'd41, 64'h4, 16'd0,      1'b1, '0};
            20: s = '{CMD_WRITE,   6'd42, 64'h7, 16'd0,      1'b1, '0};
            21: s = '{CMD_RUN,     6'd0,  64'd0, 16'd4,      1'b0, '0};
            22: s = '{CMD_READ,    6'd42, 64'd0, 16'd0,      1'b0, '0};
            23: s = '{CMD_READ,    6'd43, 64'd0, 16'd0,      1'b0, '0};
            default: s = '{CMD_READ, 6'd63, 64'd0, 16'd0,    1'b0, '0};
        endcase
        return s;
    endfunction

    // ---------------------------------------------------------------
    // Input side: one transfer per call, bursts with random gaps
    // ---------------------------------------------------------------
    task automatic send_command(input logic [1:0] op, input logic [5:0] row,
                                input row_t cells, input logic [15:0] gens,
                                input bit literal, input life_result_t want);
        life_result_t predicted;
        in_valid    <= 1'b1;
        cmd         <= op;
        row_index   <= row;
        row_cells   <= cells;
        generations <= gens;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predicted = predict_command(op, row, cells, gens);
        pending_results.push_back(literal ? want : predicted);
        items_sent++;
        case (op)
            CMD_WRITE: writes_sent++;
            CMD_READ:  reads_sent++;
            CMD_RUN:
            begin
                runs_sent++;
                gens_applied += int'(predicted.gens_done);
                if (predicted.stable)
                begin
                    stable_runs++;
                end
            end
            default:
            begin
            end
        endcase
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 15);
        end
    endtask

    // Block idle once every expected result has come back
    task automatic wait_drained(input int limit);
        int n;
        n = 0;
        while (pending_results.size() != 0 && n < limit)
        begin
            @(posedge clk);
            n++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_grid_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= REG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        width_reg  = w;
        height_reg = h;
    endtask

    function automatic row_t random_row();
        row_t a;
        row_t b;
        row_t c;
        a = {$urandom(), $urandom()};
        b = {$urandom(), $urandom()};
        c = {$urandom(), $urandom()};
        case ($urandom_range(0, 6))
            0: return a;
            1: return a & b;
            2, 3: return a & b & c;
            4: return '0;
            5: return '1;
            default: return 64'h7 << $urandom_range(0, 63);
        endcase
    endfunction

    task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
        // keep the log short when the block is badly broken
        if (mismatch_count < PRINT_CAP)
        begin
            $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------
    // Output side: stall pattern and result check
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(20, 300);
        end
        else
        begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            1: out_stall <= ($urandom_range(0, 2) == 0);
            2: out_stall <= ($urandom_range(0, 7) != 0);
            3: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("transfer with no expected result", row_cells_out, '0);
            end
            else
            begin
                head_result = pending_results.pop_front();
                results_checked++;
                if (row_cells_out !== head_result.cells)
                begin
                    report_mismatch("row_cells_out", row_cells_out, head_result.cells);
                end
                if (generations_done !== head_result.gens_done)
                begin
                    report_mismatch("generations_done", 64'(generations_done),
                                    64'(head_result.gens_done));
                end
                if (stable !== head_result.stable)
                begin
                    report_mismatch("stable", 64'(stable), 64'(head_result.stable));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin : main_seq
        stim_row_t        s;
        logic [DIM_W-1:0] wv;
        logic [DIM_W-1:0] hv;
        logic [1:0]       op;
        logic [5:0]       rv;
        logic [15:0]      gv;
        int               h_now;
        int               cap;
        int               pick;
        int               i;
        int               phase;
        int               k;

        for (i = 0; i < MAX_ROWS; i++)
        begin
            grid_rows[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset size of 64 by 64
        for (i = 0; i < DIRECTED_COUNT; i++)
        begin
            s = directed_row(i);
            send_command(s.op, s.row, s.cells, s.gens, s.literal, s.want);
        end
        in_valid <= 1'b0;

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin wv = 7'd1;   hv = 7'd1;   end
                1: begin wv = 7'd2;   hv = 7'd2;   end
                2: begin wv = 7'd3;   hv = 7'd3;   end
                3: begin wv = 7'd0;   hv = 7'd0;   end
                4: begin wv = 7'd127; hv = 7'd127; end
                5: begin wv = 7'd64;  hv = 7'd4;   end
                6: begin wv = 7'd6;   hv = 7'd64;  end
                7: begin wv = 7'($urandom_range(1, 64)); hv = 7'($urandom_range(1, 64)); end
                8: begin wv = 7'($urandom_range(0, 127)); hv = 7'($urandom_range(0, 12)); end
                default: begin wv = 7'd64; hv = 7'd64; end
            endcase
            wait_drained(200000);
            set_grid_size(wv, hv);
            h_now = clamp_size(hv, MAX_ROWS);
            cap = RUN_BUDGET / (h_now + 4);

            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                pick = $urandom_range(0, 99);
                rv = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, h_now - 1))
                                                 : 6'($urandom_range(0, 63));
                gv = 16'($urandom_range(0, 65535));
                if (pick < 38)
                begin
                    op = CMD_WRITE;
                end
                else if (pick < 68)
                begin
                    op = CMD_READ;
                end
                else if (pick < 95)
                begin
                    op = CMD_RUN;
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gv = 16'($urandom_range(0, 3));
                        4, 5, 6:    gv = 16'($urandom_range(4, 20));
                        7, 8:       gv = 16'($urandom_range(0, 65535));
                        default:    gv = 16'hFFFF;
                    endcase
                    // long runs only where the grid settles quickly
                    if (int'(gv) > cap && !settles_within(cap))
                    begin
                        gv = 16'($urandom_range(0, cap));
                    end
                end
                else
                begin
                    op = CMD_UNKNOWN;
                end
                send_command(op, rv, random_row(), gv, 1'b0, '0);
            end
            in_valid <= 1'b0;
        end

        // drain and let the pipeline settle
        wait_drained(200000);
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            report_mismatch("results never returned", 64'(pending_results.size()), 64'd0);
        end

        $display("covered %0d commands: %0d writes, %0d reads, %0d runs (%0d stopped stable)",
                 items_sent, writes_sent, reads_sent, runs_sent, stable_runs);
        $display("%0d generations applied over %0d grid sizes, %0d results checked",
                 gens_applied, PHASES + 1, results_checked);
        if (mismatch_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[life_generation_engine_top.f]
+incdir+hdl
hdl/lge_pkg.sv
hdl/lge_ram.sv
hdl/lge_lane.sv
hdl/lge_row_unit.sv
hdl/life_generation_engine_top.sv
tb/sv/tb_life_generation_engine_top.sv
